### hdl/cmwc_pkg.sv
// shared constants and types for the cmwc random generator
package cmwc_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int WORD_W      = 32;

  localparam logic [WORD_W-1:0] PHI_CONST       = 32'h9e37_79b9;
  localparam logic [WORD_W-1:0] COMPLEMENT_BASE = 32'hffff_fffe;
  localparam logic [WORD_W-1:0] CARRY_RESET     = 32'd362436;
  localparam logic [WORD_W-1:0] MULT_RESET      = 32'd19150;
  localparam logic [IDX_W-1:0]  IDX_LAST        = IDX_W'(TABLE_DEPTH - 1);

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef struct packed {
    logic mul_en;
    logic add_en;
  } mac_ctl_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SEED = 8'b0000_0010,
    ST_SACK = 8'b0000_0100,
    ST_RD   = 8'b0000_1000,
    ST_MUL  = 8'b0001_0000,
    ST_ADD  = 8'b0010_0000,
    ST_XSUM = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

endpackage

### hdl/cmwc_if.sv
// request and result channel interfaces
interface cmwc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [cmwc_pkg::WORD_W-1:0]  seed_value;

  modport source (output valid, output req_type, output seed_value, input ready);
  modport sink   (input valid, input req_type, input seed_value, output ready);
endinterface

interface cmwc_out_if;
  logic                         valid;
  logic                         ready;
  logic [cmwc_pkg::WORD_W-1:0]  random_value;
  logic                         was_seed;

  modport source (output valid, output random_value, output was_seed, input ready);
  modport sink   (input valid, input random_value, input was_seed, output ready);
endinterface

### hdl/cmwc_ram.sv
// generic single-port ram with registered read
module cmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/cmwc_mac.sv
// shared multiply-add unit, product and sum each registered
module cmwc_mac (
  input  logic                        clk,
  input  cmwc_pkg::mac_ctl_t          ctl,
  input  logic [cmwc_pkg::WORD_W-1:0] mult,
  input  logic [cmwc_pkg::WORD_W-1:0] entry,
  input  logic [cmwc_pkg::WORD_W-1:0] addend,
  output logic [2*cmwc_pkg::WORD_W-1:0] t
);
  import cmwc_pkg::*;

  logic [2*WORD_W-1:0] prod_r;
  logic [2*WORD_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= (2*WORD_W)'(mult) * (2*WORD_W)'(entry);
    end
    if (ctl.add_en) begin
      sum_r <= prod_r + {{WORD_W{1'b0}}, addend};
    end
  end

  assign t = sum_r;

endmodule

### hdl/cmwc_random_generator.sv
// cmwc random generator top: sequencer, lag table, carry and index
// draw: steps ST_RD, ST_MUL, ST_ADD, ST_XSUM, ST_FIN; next beat taken back in ST_IDLE
// seed: ST_SEED writes the table, one entry per cycle, then ST_SACK registers the result
// the sequence is set by the single ram port and the shared multiply-add unit
// a waiting result does not block the next beat; finishing waits for the output
// rst_n (sync, active low) clears carry to 362436, index to depth-1, multiplier to 19150
module cmwc_random_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  cmwc_in_if.sink                     in_ch,
  cmwc_out_if.source                  out_ch,
  input  logic                        cfg_wr_en,
  input  logic [cmwc_pkg::WORD_W-1:0] cfg_wr_data
);
  import cmwc_pkg::*;

  state_t              state_r, state_nxt;
  logic [WORD_W-1:0]   mult_r;
  logic [WORD_W-1:0]   carry_r, carry_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    k_r, k_nxt;
  logic [WORD_W-1:0]   seed_r;
  logic [WORD_W-1:0]   w0_r, w1_r, w2_r;
  logic [WORD_W-1:0]   x_r;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_value_r;
  logic                out_seed_r;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_addr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]   seed_word;
  logic                out_free;
  logic                x_wrap;
  logic [WORD_W-1:0]   x_fix;
  logic [WORD_W-1:0]   result;
  logic [2*WORD_W-1:0] t;
  mac_ctl_t            mac_ctl;

  cmwc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  cmwc_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .mult   (mult_r),
    .entry  (ram_rdata),
    .addend (carry_r),
    .t      (t)
  );

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // seed sequence from a three-entry window
  always_comb begin
    if (k_r == '0) begin
      seed_word = seed_r;
    end else if (k_r < IDX_W'(3)) begin
      seed_word = w2_r + PHI_CONST;
    end else begin
      seed_word = w0_r ^ w1_r ^ PHI_CONST ^ WORD_W'(k_r);
    end
  end

  // carry correction and complement
  assign x_wrap = (x_r < carry_r);
  assign x_fix  = x_wrap ? x_r + 1'b1 : x_r;
  assign result = COMPLEMENT_BASE - x_fix;

  always_comb begin
    state_nxt      = state_r;
    carry_nxt      = carry_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    ram_we         = 1'b0;
    ram_addr       = idx_r;
    ram_wdata      = result;
    mac_ctl.mul_en = 1'b0;
    mac_ctl.add_en = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.req_type == REQ_SEED) begin
            state_nxt = ST_SEED;
            k_nxt     = '0;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_SEED: begin
        ram_we    = 1'b1;
        ram_addr  = k_r;
        ram_wdata = seed_word;
        k_nxt     = k_r + 1'b1;
        if (k_r == IDX_LAST) begin
          state_nxt = ST_SACK;
        end
      end
      ST_SACK: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        idx_nxt   = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
        ram_addr  = idx_nxt;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_nxt      = ST_ADD;
      end
      ST_ADD: begin
        mac_ctl.add_en = 1'b1;
        state_nxt      = ST_XSUM;
      end
      ST_XSUM: begin
        carry_nxt = t[2*WORD_W-1:WORD_W];
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          ram_we    = 1'b1;
          carry_nxt = x_wrap ? carry_r + 1'b1 : carry_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mult_r      <= MULT_RESET;
      carry_r     <= CARRY_RESET;
      idx_r       <= IDX_LAST;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      carry_r <= carry_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
      if (cfg_wr_en) begin
        mult_r <= cfg_wr_data;
      end
      if (state_r == ST_SACK && out_free) begin
        out_valid_r <= 1'b1;
      end else if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      seed_r <= in_ch.seed_value;
    end
    if (state_r == ST_SEED) begin
      w0_r <= w1_r;
      w1_r <= w2_r;
      w2_r <= seed_word;
    end
    if (state_r == ST_XSUM) begin
      x_r <= t[WORD_W-1:0] + t[2*WORD_W-1:WORD_W];
    end
    if (state_r == ST_SACK && out_free) begin
      out_value_r <= '0;
      out_seed_r  <= 1'b1;
    end else if (state_r == ST_FIN && out_free) begin
      out_value_r <= result;
      out_seed_r  <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.random_value = out_value_r;
  assign out_ch.was_seed     = out_seed_r;

endmodule
